>>> sv/skrl_pkg.sv
// ----------------------------------------------------------------------------
// skrl_pkg: shared types and constants
// Request/response structs, opcodes and default sizes for the sorted key
// table run lookup.
// ----------------------------------------------------------------------------
package skrl_pkg;

  localparam int unsigned DefTableDepth = 4096;
  localparam int unsigned DefMaxRun     = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [11:0] entry_index;
    logic [63:0] search_key;
    logic [15:0] entry_move;
    logic [15:0] entry_weight;
    logic [31:0] entry_learn;
  } skrl_req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] result_move;
    logic [15:0] result_weight;
    logic [31:0] result_learn;
    logic        truncated;
    logic        last;
  } skrl_rsp_t;

endpackage

>>> sv/skrl_store.sv
// ----------------------------------------------------------------------------
// skrl_store: key and payload table
// Two single-port-write, single-port-read memories with registered read data.
// ----------------------------------------------------------------------------
module skrl_store #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned AW          = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wkey_i,
  input  logic [63:0]   wpay_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rkey_o,
  output logic [63:0]   rpay_o
);

  logic [63:0] key_mem [TABLE_DEPTH];
  logic [63:0] pay_mem [TABLE_DEPTH];

  // write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      pay_mem[waddr_i] <= wpay_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rkey_o <= key_mem[raddr_i];
      rpay_o <= pay_mem[raddr_i];
    end
  end

endmodule

>>> sv/skrl_run.sv
// ----------------------------------------------------------------------------
// skrl_run: run buffer
// Holds the payloads of the collected run; one write, one registered read.
// ----------------------------------------------------------------------------
module skrl_run #(
  parameter int unsigned MAX_RUN = 16,
  parameter int unsigned RW      = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [RW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic          re_i,
  input  logic [RW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] run_mem [MAX_RUN];

  // store one payload
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      run_mem[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= run_mem[raddr_i];
    end
  end

endmodule

>>> sv/sorted_key_table_run_lookup.sv
// ----------------------------------------------------------------------------
// sorted_key_table_run_lookup: sorted table with run lookup
// A write request stores one entry when its index is in range. A query runs a
// binary search (log2 of entry_count + 1 probes), collects the run of matching
// entries into the run buffer, and does a selection scan of the run buffer per result,
// all bounded by the single table read port and the one weight comparator.
// Reset clears control state; table contents are undefined until written.
// ----------------------------------------------------------------------------
module sorted_key_table_run_lookup
  import skrl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned MAX_RUN     = DefMaxRun
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  skrl_req_t   in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output skrl_rsp_t   out_rsp_o
);

  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RW  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int unsigned NW  = $clog2(MAX_RUN + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PROBE = 4'd1;
  localparam logic [3:0] ST_PWAIT = 4'd2;
  localparam logic [3:0] ST_SCAN  = 4'd3;
  localparam logic [3:0] ST_SWAIT = 4'd4;
  localparam logic [3:0] ST_SEL   = 4'd5;
  localparam logic [3:0] ST_EMIT  = 4'd6;

  logic [3:0]    state_q, state_d;
  logic [12:0]   ent_q;
  logic [63:0]   key_q, key_d;
  logic [CW-1:0] n_q, n_d, low_q, low_d, high_q, high_d;
  logic [CW-1:0] mid_q, mid_d, first_q, first_d, idx_q, idx_d;
  logic [NW-1:0] cnt_q, cnt_d, emit_q, emit_d, sel_q, sel_d;
  logic          trunc_q, trunc_d, miss_q, miss_d;
  logic [MAX_RUN-1:0] taken_q, taken_d;
  logic          rvld_q, rvld_d;
  logic [RW-1:0] ridx_q, ridx_d;
  logic          bvld_q, bvld_d;
  logic [15:0]   bw_q, bw_d;
  logic [RW-1:0] bidx_q, bidx_d;
  logic [63:0]   bpay_q, bpay_d;
  logic          ovld_q, ovld_d;
  skrl_rsp_t     orsp_q, orsp_d;

  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [63:0]   st_rkey, st_rpay;
  logic          rb_we, rb_re;
  logic [RW-1:0] rb_raddr;
  logic [63:0]   rb_rdata;
  logic [CW-1:0] n_lim;
  logic [CW-1:0] mid_calc;
  logic          upd;

  skrl_store #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wkey_i  (in_req_i.search_key),
    .wpay_i  ({in_req_i.entry_move, in_req_i.entry_weight, in_req_i.entry_learn}),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rkey_o  (st_rkey),
    .rpay_o  (st_rpay)
  );

  skrl_run #(.MAX_RUN(MAX_RUN), .RW(RW)) u_run (
    .clk_i   (clk_i),
    .we_i    (rb_we),
    .waddr_i (RW'(cnt_q)),
    .wdata_i (st_rpay),
    .re_i    (rb_re),
    .raddr_i (rb_raddr),
    .rdata_o (rb_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovld_q;
  assign out_rsp_o   = orsp_q;

  // clamp the count to the table size
  assign n_lim = (32'(ent_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(ent_q);
  assign mid_calc = low_q + ((high_q - low_q) >> 1);
  assign st_waddr = AW'(in_req_i.entry_index);
  assign rb_raddr = RW'(sel_q);

  // weight compare of the shared selection scan
  assign upd = rvld_q && !taken_q[ridx_q] && (!bvld_q || (rb_rdata[47:32] > bw_q));

  // sequencer
  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    n_d     = n_q;
    low_d   = low_q;
    high_d  = high_q;
    mid_d   = mid_q;
    first_d = first_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    emit_d  = emit_q;
    sel_d   = sel_q;
    trunc_d = trunc_q;
    miss_d  = miss_q;
    taken_d = taken_q;
    rvld_d  = 1'b0;
    ridx_d  = ridx_q;
    bvld_d  = bvld_q;
    bw_d    = bw_q;
    bidx_d  = bidx_q;
    bpay_d  = bpay_q;
    ovld_d  = ovld_q;
    orsp_d  = orsp_q;
    st_we   = 1'b0;
    st_re   = 1'b0;
    st_raddr = AW'(mid_q);
    rb_we   = 1'b0;
    rb_re   = 1'b0;

    // drop the result once taken
    if (ovld_q && out_ready_i) begin
      ovld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.opcode == OP_WRITE) begin
            st_we = (32'(in_req_i.entry_index) < 32'(TABLE_DEPTH));
          end else begin
            key_d   = in_req_i.search_key;
            n_d     = n_lim;
            low_d   = '0;
            high_d  = n_lim - CW'(1);
            first_d = n_lim;
            cnt_d   = '0;
            emit_d  = '0;
            trunc_d = 1'b0;
            taken_d = '0;
            miss_d  = (n_lim == '0);
            state_d = (n_lim == '0) ? ST_EMIT : ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        mid_d    = mid_calc;
        st_re    = 1'b1;
        st_raddr = AW'(mid_calc);
        state_d  = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (st_rkey < key_q) begin
          low_d   = mid_q + CW'(1);
          state_d = (mid_q + CW'(1) <= high_q) ? ST_PROBE : ST_SCAN;
        end else begin
          if (st_rkey == key_q) begin
            first_d = mid_q;
          end
          high_d  = mid_q - CW'(1);
          state_d = ((mid_q != '0) && (low_q <= mid_q - CW'(1))) ? ST_PROBE : ST_SCAN;
        end
        if (state_d == ST_SCAN) begin
          idx_d = (st_rkey == key_q) ? mid_q : first_q;
          if (st_rkey != key_q && first_q == n_q) begin
            miss_d  = 1'b1;
            state_d = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        st_re    = 1'b1;
        st_raddr = AW'(idx_q);
        state_d  = ST_SWAIT;
      end
      ST_SWAIT: begin
        state_d = ST_SEL;
        if (st_rkey == key_q) begin
          if (32'(cnt_q) == 32'(MAX_RUN)) begin
            trunc_d = 1'b1;
          end else begin
            rb_we = 1'b1;
            cnt_d = cnt_q + NW'(1);
            idx_d = idx_q + CW'(1);
            if (idx_q + CW'(1) < n_q) begin
              state_d = ST_SCAN;
            end
          end
        end
        if (state_d == ST_SEL) begin
          sel_d  = '0;
          bvld_d = 1'b0;
        end
      end
      ST_SEL: begin
        // issue the next read, fold in the last one
        if (sel_q < cnt_q) begin
          rb_re  = 1'b1;
          rvld_d = 1'b1;
          ridx_d = RW'(sel_q);
          sel_d  = sel_q + NW'(1);
        end
        if (upd) begin
          bvld_d = 1'b1;
          bw_d   = rb_rdata[47:32];
          bidx_d = ridx_q;
          bpay_d = rb_rdata;
        end
        if (rvld_q && (32'(ridx_q) + 32'd1 == 32'(cnt_q))) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ovld_q || out_ready_i) begin
          ovld_d = 1'b1;
          if (miss_q) begin
            orsp_d  = '0;
            orsp_d.last = 1'b1;
            state_d = ST_IDLE;
          end else begin
            orsp_d.found         = 1'b1;
            orsp_d.result_move   = bpay_q[63:48];
            orsp_d.result_weight = bpay_q[47:32];
            orsp_d.result_learn  = bpay_q[31:0];
            orsp_d.truncated     = trunc_q;
            orsp_d.last          = (emit_q + NW'(1) == cnt_q);
            taken_d[bidx_q]      = 1'b1;
            emit_d               = emit_q + NW'(1);
            sel_d                = '0;
            bvld_d               = 1'b0;
            state_d = (emit_q + NW'(1) == cnt_q) ? ST_IDLE : ST_SEL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ent_q   <= '0;
      ovld_q  <= 1'b0;
      rvld_q  <= 1'b0;
      bvld_q  <= 1'b0;
      taken_q <= '0;
      miss_q  <= 1'b0;
      trunc_q <= 1'b0;
      cnt_q   <= '0;
      emit_q  <= '0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        ent_q <= cfg_wdata_i;
      end
      ovld_q  <= ovld_d;
      rvld_q  <= rvld_d;
      bvld_q  <= bvld_d;
      taken_q <= taken_d;
      miss_q  <= miss_d;
      trunc_q <= trunc_d;
      cnt_q   <= cnt_d;
      emit_q  <= emit_d;
      sel_q   <= sel_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    n_q     <= n_d;
    low_q   <= low_d;
    high_q  <= high_d;
    mid_q   <= mid_d;
    first_q <= first_d;
    idx_q   <= idx_d;
    ridx_q  <= ridx_d;
    bw_q    <= bw_d;
    bidx_q  <= bidx_d;
    bpay_q  <= bpay_d;
    orsp_q  <= orsp_d;
  end

endmodule

>>> sv/skrl_checker.sv
// ----------------------------------------------------------------------------
// skrl_checker: port-level checks
// Watches the top level's ports for response and handshake consistency.
// ----------------------------------------------------------------------------
module skrl_checker
  import skrl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input skrl_req_t in_req_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input skrl_rsp_t out_rsp_o
);

  // hold a stalled response
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response dropped while stalled");

  // a query keeps the block busy for the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.opcode == OP_QUERY) |=> !in_ready_o)
    else $error("ready right after a query");

  // a miss is a single final result
  a_miss_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.found |-> out_rsp_o.last)
    else $error("miss result not last");

  // a miss carries no truncation flag
  a_miss_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.found |-> !out_rsp_o.truncated)
    else $error("miss result flagged truncated");

endmodule

bind sorted_key_table_run_lookup skrl_checker u_skrl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
